>>> rtl/assert_macros.svh
// Assertion macros used by the console writer sequencer (tcw_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check cons in the cycle after ante.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/tcw_pkg.sv
// Types and constants of the text console writer.
package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam int CFG_W = 4;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [CFG_W-1:0] RESET_FOREGROUND = 4'hF;
  localparam logic [CFG_W-1:0] RESET_BACKGROUND = 4'h0;
  localparam logic [7:0]       RESET_ATTR       = 8'h0F;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] read_data;
  } tcw_out_t;

endpackage

>>> rtl/tcw_mem.sv
// Cell store: one write port, one read port with registered read data.
module tcw_mem #(
  parameter int DEPTH = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

>>> rtl/tcw_ctrl.sv
// Cursor logic and sequencer for character writes, scroll, clear, reads and the reset blanking pass.
`include "assert_macros.svh"

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int ROWS    = tcw_pkg::TCW_ROWS,
  localparam int AW = $clog2(COLUMNS * ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::tcw_in_t in_data,
  input  logic [7:0]       attr,
  output logic             res_valid,
  input  logic             res_take,
  output tcw_pkg::tcw_out_t res_data,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [15:0]      mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [15:0]      mem_rdata
);

  import tcw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
  localparam int CXW       = $clog2(COLUMNS);
  localparam int RXW       = $clog2(ROWS);
  localparam int CW        = $clog2(COLUMNS + 8);
  localparam int RW        = $clog2(ROWS + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RESULT = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0]     state, state_next;
  logic [CXW-1:0] cur_col, cur_col_next;
  logic [RXW-1:0] cur_row, cur_row_next;
  logic [AW-1:0]  sweep, sweep_next;
  logic           rd_ok, rd_ok_next;
  logic           p_valid, p_valid_next;
  logic [AW-1:0]  p_addr, p_addr_next;
  logic           p_copy, p_copy_next;
  logic [15:0]    p_data, p_data_next;

  logic           accept;
  logic [31:0]    pos_full;
  logic [AW-1:0]  cur_pos;
  logic           sweep_last;
  logic [CW-1:0]  col_t;
  logic [RW-1:0]  row_t;
  logic           put_write;
  logic           put_scroll;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE) || p_valid;
  assign pos_full   = 32'(cur_row) * COLUMNS + 32'(cur_col);
  assign cur_pos    = AW'(pos_full);
  assign sweep_last = (sweep == AW'(CELLS - 1));

  always_comb begin
    put_write = 1'b0;
    col_t     = CW'(cur_col);
    row_t     = RW'(cur_row);
    unique case (in_data.char_code)
      CH_LF: begin
        col_t = '0;
        row_t = row_t + RW'(1);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_TAB: begin
        col_t = (col_t + CW'(8)) & ~CW'(7);
      end
      CH_BS: begin
        if (col_t != '0) begin
          col_t = col_t - CW'(1);
        end
      end
      default: begin
        if (!in_data.char_code[7] && (in_data.char_code >= CH_SPACE)) begin
          put_write = 1'b1;
          col_t     = col_t + CW'(1);
        end
      end
    endcase
    if (32'(col_t) >= COLUMNS) begin
      col_t = '0;
      row_t = row_t + RW'(1);
    end
    put_scroll = (32'(row_t) >= ROWS);
  end

  always_comb begin
    state_next   = state;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    sweep_next   = sweep;
    rd_ok_next   = rd_ok;
    p_valid_next = 1'b0;
    p_addr_next  = p_addr;
    p_copy_next  = 1'b0;
    p_data_next  = p_data;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    unique case (state)
      S_INIT: begin
        p_valid_next = 1'b1;
        p_addr_next  = sweep;
        p_data_next  = {RESET_ATTR, CH_SPACE};
        sweep_next   = sweep_last ? '0 : sweep + AW'(1);
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rd_ok_next = 1'b0;
          unique case (in_data.op)
            OP_PUT: begin
              p_valid_next = put_write;
              p_addr_next  = cur_pos;
              p_data_next  = {attr, in_data.char_code};
              cur_col_next = CXW'(col_t);
              if (put_scroll) begin
                cur_row_next = RXW'(ROWS - 1);
                state_next   = S_SCROLL;
              end else begin
                cur_row_next = RXW'(row_t);
                state_next   = S_RESULT;
              end
            end
            OP_CLEAR: begin
              cur_col_next = '0;
              cur_row_next = '0;
              state_next   = S_FILL;
            end
            OP_READ: begin
              rd_ok_next = (32'(in_data.cell_index) < CELLS);
              mem_re     = 1'b1;
              mem_raddr  = AW'(in_data.cell_index);
              state_next = S_RESULT;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_SCROLL: begin
        p_valid_next = 1'b1;
        p_addr_next  = sweep;
        p_data_next  = {attr, CH_SPACE};
        if (32'(sweep) < LAST_BASE) begin
          p_copy_next = 1'b1;
          mem_re      = 1'b1;
          mem_raddr   = AW'(32'(sweep) + COLUMNS);
        end
        sweep_next = sweep_last ? '0 : sweep + AW'(1);
        if (sweep_last) begin
          state_next = S_RESULT;
        end
      end
      S_FILL: begin
        p_valid_next = 1'b1;
        p_addr_next  = sweep;
        p_data_next  = {attr, CH_SPACE};
        sweep_next   = sweep_last ? '0 : sweep + AW'(1);
        if (sweep_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cur_col <= '0;
      cur_row <= '0;
      sweep   <= '0;
      rd_ok   <= 1'b0;
      p_valid <= 1'b0;
      p_copy  <= 1'b0;
    end else begin
      state   <= state_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      sweep   <= sweep_next;
      rd_ok   <= rd_ok_next;
      p_valid <= p_valid_next;
      p_copy  <= p_copy_next;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= p_addr_next;
    p_data <= p_data_next;
  end

  assign mem_we    = p_valid;
  assign mem_waddr = p_addr;
  assign mem_wdata = p_copy ? mem_rdata : p_data;

  assign res_valid                = (state == S_RESULT);
  assign res_data.cursor_position = 11'(pos_full);
  assign res_data.read_data       = rd_ok ? mem_rdata : 16'h0000;

  `TCW_ASSERT_NOW(a_cursor_in_range, clk, rst, 1'b1,
                  (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
  `TCW_ASSERT_NEXT(a_read_to_result, clk, rst, accept && (in_data.op == OP_READ),
                   state == S_RESULT)
  `TCW_ASSERT_NOW(a_copy_read_ahead, clk, rst, mem_re && p_copy && (state == S_SCROLL),
                  mem_raddr > p_addr)
  `TCW_ASSERT_NEXT(a_scroll_cursor, clk, rst, state == S_SCROLL,
                   (cur_row == RXW'(ROWS - 1)) && (cur_col == '0))

endmodule

>>> rtl/text_console_writer_top.sv
// Text console writer top level: config registers, result register, sequencer, cell store.
// A character put, a read or an unused op is decoded in the accepting cycle, which also
// issues the cell read of a read; the sequencer then waits in its result state until the
// result register can take the result, and returns to idle to take the next transaction. A put
// that moves the cursor past the last row adds a scroll over all ROWS*COLUMNS cells,
// one cell per cycle through the single write port of the cell store, and a clear
// takes the same ROWS*COLUMNS-cell sweep. After reset the store is blanked by a pass over
// all ROWS*COLUMNS cells during which no transaction is accepted; configuration writes are
// taken throughout.
// A result waiting in the output register does not block the next input transaction.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tcw_pkg::tcw_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tcw_pkg::tcw_out_t         out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0] cfg_data
);

  import tcw_pkg::*;

  localparam int AW = $clog2(COLUMNS * ROWS);

  logic [CFG_W-1:0] foreground;
  logic [CFG_W-1:0] background;
  logic             res_valid;
  logic             res_take;
  tcw_out_t         res_data;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [15:0]      mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      foreground <= RESET_FOREGROUND;
      background <= RESET_BACKGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOREGROUND: foreground <= cfg_data;
        REG_BACKGROUND: background <= cfg_data;
      endcase
    end
  end

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data <= res_data;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .attr      ({background, foreground}),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (COLUMNS * ROWS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
